>>> rtl/zero_copy_send_completion_tracker_unit_macros.svh
// Assertion helpers for the completion tracker.
`ifndef ZERO_COPY_SEND_COMPLETION_TRACKER_UNIT_MACROS_SVH
`define ZERO_COPY_SEND_COMPLETION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ZCSCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ZCSCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/zcsct_pkg.sv
package zcsct_pkg;

    localparam int CNT_WIDTH_DEF = 48;
    localparam int NUM_COUNTERS  = 7;
    localparam int ROW_SLOTS     = 4;

    localparam int MIN_ATT_W   = 32;
    localparam int MIN_BYTES_W = 48;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;

    localparam logic [MIN_ATT_W-1:0]   MIN_ATT_RST   = 32'd1024;
    localparam logic [MIN_BYTES_W-1:0] MIN_BYTES_RST = 48'd16777216;

    localparam logic [1:0] FUNC_EVENT     = 2'd0;
    localparam logic [1:0] FUNC_ARM_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_READ      = 2'd2;

    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_COMPLETE    = 3'd1;
    localparam logic [2:0] ACT_RESUBMIT    = 3'd2;
    localparam logic [2:0] ACT_CLOSE_ERR   = 3'd3;
    localparam logic [2:0] ACT_CLOSE_NOTIF = 3'd4;

    localparam logic [1:0] PEND_NONE      = 2'd0;
    localparam logic [1:0] PEND_COMPLETE  = 2'd1;
    localparam logic [1:0] PEND_RESUBMIT  = 2'd2;
    localparam logic [1:0] PEND_CLOSE_ERR = 2'd3;

    localparam logic [2:0] CNT_NOTIF    = 3'd0;
    localparam logic [2:0] CNT_COPIED   = 3'd1;
    localparam logic [2:0] CNT_NO_NOTIF = 3'd2;
    localparam logic [2:0] CNT_OOM      = 3'd3;
    localparam logic [2:0] CNT_OTHER    = 3'd4;
    localparam logic [2:0] CNT_BYTES    = 3'd5;
    localparam logic [2:0] CNT_DISABLE  = 3'd6;

    // Counter rows: notification row holds notif/copied/disable,
    // send row holds no-notif/oom/other/bytes.
    localparam logic ROW_NOTIF = 1'b0;
    localparam logic ROW_SEND  = 1'b1;

    localparam logic [1:0] SLOT_NOTIF    = 2'd0;
    localparam logic [1:0] SLOT_COPIED   = 2'd1;
    localparam logic [1:0] SLOT_DISABLE  = 2'd2;
    localparam logic [1:0] SLOT_NO_NOTIF = 2'd0;
    localparam logic [1:0] SLOT_OOM      = 2'd1;
    localparam logic [1:0] SLOT_OTHER    = 2'd2;
    localparam logic [1:0] SLOT_BYTES    = 2'd3;

    function automatic logic cnt_row(input logic [2:0] idx);
        logic r;
        case (idx)
            CNT_NOTIF, CNT_COPIED, CNT_DISABLE: r = ROW_NOTIF;
            CNT_NO_NOTIF, CNT_OOM, CNT_OTHER, CNT_BYTES: r = ROW_SEND;
            default: r = ROW_NOTIF;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cnt_slot(input logic [2:0] idx);
        logic [1:0] s;
        case (idx)
            CNT_NOTIF:    s = SLOT_NOTIF;
            CNT_COPIED:   s = SLOT_COPIED;
            CNT_DISABLE:  s = SLOT_DISABLE;
            CNT_NO_NOTIF: s = SLOT_NO_NOTIF;
            CNT_OOM:      s = SLOT_OOM;
            CNT_OTHER:    s = SLOT_OTHER;
            CNT_BYTES:    s = SLOT_BYTES;
            default:      s = SLOT_NOTIF;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/zero_copy_send_completion_tracker_unit.sv
// Zero-copy send completion tracker.
// Input channel (i_in_valid / o_in_ready) takes one word per event: a send
// completion or notification (func 0), an arm-close request (func 1) or a
// counter read (func 2). Output channel (o_out_valid / i_out_ready) returns
// one word per input word, in order.
// Result words pass through the stage-1 registers and the output register.
// Throughput: one word per cycle unless the receiver stalls. Event counters
// sit in a 2-row memory (one row per event class); each word does one read,
// event words a write-back too; the last forwards to a following same-row word.
// When the receiver stalls, the output register holds its word, one more
// word waits in the compute stage, and o_in_ready drops.
// Reset (synchronous, active low) clears the flags, re-enables zero copy,
// loads the register defaults and marks both counter rows as zero at once.
// APB port: min_attempts at 0x0, min_bytes_requested at 0x8, 64-bit data, pready
// always high; the user writes only while the block is idle, which the block does not enforce.
`include "zero_copy_send_completion_tracker_unit_macros.svh"

module zero_copy_send_completion_tracker_unit
    import zcsct_pkg::*;
#(
    parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_func,
    input  logic signed [31:0]       i_send_result,
    input  logic                     i_is_notification,
    input  logic                     i_more_flag,
    input  logic                     i_data_copied,
    input  logic                     i_out_of_memory_error,
    input  logic [31:0]              i_written_before,
    input  logic [31:0]              i_response_total,
    input  logic [47:0]              i_attempts_so_far,
    input  logic [47:0]              i_bytes_requested_so_far,
    input  logic [2:0]               i_counter_index,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_action,
    output logic [30:0]              o_acct_bytes,
    output logic                     o_zc_shutoff,
    output logic                     o_zero_copy_on,
    output logic                     o_awaiting_notification,
    output logic [COUNTER_WIDTH-1:0] o_counter_value
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int ROW_W = ROW_SLOTS * CW;
    localparam int SUM_W = ((CW > 31) ? CW : 31) + 1;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + CW'(1);
    endfunction

    // config registers
    logic [MIN_ATT_W-1:0]   r_min_att;
    logic [MIN_BYTES_W-1:0] r_min_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_att   <= MIN_ATT_RST;
            r_min_bytes <= MIN_BYTES_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3]) begin
                r_min_bytes <= pwdata[MIN_BYTES_W-1:0];
            end else begin
                r_min_att <= pwdata[MIN_ATT_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? {{(CFG_DATA_W-MIN_BYTES_W){1'b0}}, r_min_bytes}
                             : {{(CFG_DATA_W-MIN_ATT_W){1'b0}}, r_min_att};

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic s1_fire;
    logic in_fire;

    assign s1_adv     = !r_s1_valid || !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = s1_adv;
    assign in_fire    = i_in_valid && s1_adv;

    // counter memory
    logic [ROW_W-1:0] r_mem [2];
    logic [1:0]       r_row_vld;
    logic [ROW_W-1:0] r_rd;
    logic             r_rd_vld;
    logic             rd_row;

    logic             wb_en;
    logic [ROW_W-1:0] wb_data;
    logic             r_wb_vld;
    logic             r_wb_row;
    logic [ROW_W-1:0] r_wb_data;

    assign rd_row = (i_func == FUNC_READ) ? cnt_row(i_counter_index) :
                    (i_is_notification ? ROW_NOTIF : ROW_SEND);

    // stage 1 registers
    logic [1:0]  r_s1_func;
    logic [31:0] r_s1_result;
    logic        r_s1_notif;
    logic        r_s1_more;
    logic        r_s1_copied;
    logic        r_s1_oom;
    logic [31:0] r_s1_written;
    logic [31:0] r_s1_total;
    logic [47:0] r_s1_attempts;
    logic [47:0] r_s1_requested;
    logic [2:0]  r_s1_cidx;
    logic        r_s1_row;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd           <= r_mem[rd_row];
            r_rd_vld       <= r_row_vld[rd_row];
            r_s1_func      <= i_func;
            r_s1_result    <= i_send_result;
            r_s1_notif     <= i_is_notification;
            r_s1_more      <= i_more_flag;
            r_s1_copied    <= i_data_copied;
            r_s1_oom       <= i_out_of_memory_error;
            r_s1_written   <= i_written_before;
            r_s1_total     <= i_response_total;
            r_s1_attempts  <= i_attempts_so_far;
            r_s1_requested <= i_bytes_requested_so_far;
            r_s1_cidx      <= i_counter_index;
            r_s1_row       <= rd_row;
        end
        if (s1_fire && wb_en) begin
            r_mem[r_s1_row] <= wb_data;
            r_wb_row        <= r_s1_row;
            r_wb_data       <= wb_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= 2'b00;
            r_wb_vld  <= 1'b0;
        end else if (s1_fire && wb_en) begin
            r_row_vld[r_s1_row] <= 1'b1;
            r_wb_vld            <= 1'b1;
        end
    end

    // flags
    logic       r_waiting;
    logic       r_close_armed;
    logic [1:0] r_pending;
    logic       r_zc_en;
    logic       n_waiting;
    logic       n_close_armed;
    logic [1:0] n_pending;
    logic       n_zc_en;

    // stage 1 compute
    logic [ROW_W-1:0] row_data;
    logic [CW-1:0]    c0, c1, c2, c3;
    logic [CW-1:0]    n0, n1;
    logic [CW+3:0]    copied10, total9;
    logic [SUM_W-1:0] byte_sum;
    logic [32:0]      resp_sum;
    logic             done;
    logic             negative;
    logic [30:0]      sent;
    logic [2:0]       action;
    logic             disabled;
    logic [CW-1:0]    cval;

    assign row_data = (r_wb_vld && (r_wb_row == r_s1_row)) ? r_wb_data :
                      (r_rd_vld ? r_rd : '0);
    assign c0 = row_data[0*CW +: CW];
    assign c1 = row_data[1*CW +: CW];
    assign c2 = row_data[2*CW +: CW];
    assign c3 = row_data[3*CW +: CW];

    assign negative = r_s1_result[31];
    assign n0       = sat_inc(c0);
    assign n1       = r_s1_copied ? sat_inc(c1) : c1;
    assign copied10 = {n1, 3'b000} + {2'b00, n1, 1'b0};
    assign total9   = {n0, 3'b000} + {4'b0000, n0};
    assign byte_sum = SUM_W'(c3) + SUM_W'(r_s1_result[30:0]);
    assign resp_sum = {1'b0, r_s1_written} + {2'b00, r_s1_result[30:0]};
    assign done     = resp_sum >= {1'b0, r_s1_total};

    always_comb begin
        n_waiting     = r_waiting;
        n_close_armed = r_close_armed;
        n_pending     = r_pending;
        n_zc_en       = r_zc_en;
        wb_en         = 1'b0;
        wb_data       = row_data;
        action        = ACT_NONE;
        sent          = '0;
        disabled      = 1'b0;
        cval          = '0;
        case (r_s1_func)
            FUNC_ARM_CLOSE: begin
                n_close_armed = 1'b1;
            end
            FUNC_READ: begin
                if (r_s1_cidx != 3'(NUM_COUNTERS)) begin
                    cval = row_data[cnt_slot(r_s1_cidx)*CW +: CW];
                end
            end
            FUNC_EVENT: begin
                wb_en = 1'b1;
                if (r_s1_notif) begin
                    wb_data[SLOT_NOTIF*CW +: CW]  = n0;
                    wb_data[SLOT_COPIED*CW +: CW] = n1;
                    if (r_s1_copied && r_zc_en
                        && (r_s1_attempts >= {16'h0000, r_min_att})
                        && (r_s1_requested >= r_min_bytes)
                        && (copied10 > total9)) begin
                        n_zc_en  = 1'b0;
                        disabled = 1'b1;
                        wb_data[SLOT_DISABLE*CW +: CW] = sat_inc(c2);
                    end
                    n_waiting = 1'b0;
                    if (r_close_armed) begin
                        n_close_armed = 1'b0;
                        action        = ACT_CLOSE_NOTIF;
                    end else begin
                        action = {1'b0, r_pending};
                    end
                    n_pending = PEND_NONE;
                end else begin
                    if (!r_s1_more) begin
                        wb_data[SLOT_NO_NOTIF*CW +: CW] = sat_inc(c0);
                    end
                    if (negative) begin
                        if (r_s1_oom) begin
                            wb_data[SLOT_OOM*CW +: CW] = sat_inc(c1);
                        end else begin
                            wb_data[SLOT_OTHER*CW +: CW] = sat_inc(c2);
                        end
                        if (r_s1_more) begin
                            n_waiting = 1'b1;
                            n_pending = PEND_CLOSE_ERR;
                        end else begin
                            action = ACT_CLOSE_ERR;
                        end
                    end else begin
                        sent = r_s1_result[30:0];
                        wb_data[SLOT_BYTES*CW +: CW] =
                            (byte_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : byte_sum[CW-1:0];
                        if (r_s1_more) begin
                            n_waiting = 1'b1;
                            n_pending = done ? PEND_COMPLETE : PEND_RESUBMIT;
                        end else begin
                            action = done ? ACT_COMPLETE : ACT_RESUBMIT;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_waiting     <= 1'b0;
            r_close_armed <= 1'b0;
            r_pending     <= PEND_NONE;
            r_zc_en       <= 1'b1;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_out_valid   <= 1'b1;
                r_waiting     <= n_waiting;
                r_close_armed <= n_close_armed;
                r_pending     <= n_pending;
                r_zc_en       <= n_zc_en;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            o_action                <= action;
            o_acct_bytes            <= sent;
            o_zc_shutoff            <= disabled;
            o_zero_copy_on          <= n_zc_en;
            o_awaiting_notification <= n_waiting;
            o_counter_value         <= cval;
        end
    end

    assign o_out_valid = r_out_valid;

    `ZCSCT_ASSERT_NXT(a_zc_stays_off, i_clk, i_rst_n, !r_zc_en, !r_zc_en,
        "zero copy re-enabled after adaptive disable")
    `ZCSCT_ASSERT_IMP(a_disable_flag, i_clk, i_rst_n,
        o_out_valid && o_zc_shutoff, !o_zero_copy_on,
        "adaptive disable reported with zero copy still on")
    `ZCSCT_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n, !o_in_ready,
        r_s1_valid && r_out_valid && !i_out_ready,
        "input stalled without a full pipeline")
    `ZCSCT_ASSERT_IMP(a_close_cleared, i_clk, i_rst_n,
        o_out_valid && (o_action == ACT_CLOSE_NOTIF), !r_close_armed,
        "close still armed after close-after-notification")

endmodule
